FILE: hdl/icmpe_pkg.sv
// ----------------------------------------------------------------------------
// icmpe_pkg
// Shared constants and controller/datapath signal groups for the ICMP echo
// responder.
// ----------------------------------------------------------------------------
package icmpe_pkg;

    localparam int unsigned MIN_FRAME   = 98;
    localparam int unsigned ETYPE_OFF   = 12;
    localparam int unsigned IP_OFF      = 14;
    localparam int unsigned PROTO_OFF   = 23;
    localparam int unsigned IPCS_OFF    = 24;
    localparam int unsigned SRC_OFF     = 26;
    localparam int unsigned DST_OFF     = 30;
    localparam int unsigned ICMP_OFF    = 34;
    localparam int unsigned ICMPCS_OFF  = 36;
    localparam int unsigned REPLY_WORDS = (64 + 20) / 2;
    localparam int unsigned WORD_W      = $clog2(REPLY_WORDS);
    localparam int unsigned SUM_W       = 21;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [31:0] HOST_IP_RESET  = 32'hC0A8_0402;

    typedef struct packed {
        logic rx_en;
        logic fold;
        logic rd;
        logic load;
        logic next_word;
    } t_ctrl_cmd;

    typedef struct packed {
        logic frame_ok;
        logic tx_taken;
        logic last_word;
    } t_dp_status;

endpackage

FILE: hdl/icmpe_rx_if.sv
// ----------------------------------------------------------------------------
// icmpe_rx_if
// Receive byte stream: one frame byte per request with end and host flags.
// ----------------------------------------------------------------------------
interface icmpe_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       to_host;

    modport source (output valid, output rx_byte, output rx_last, output to_host,
                    input ready);
    modport sink   (input valid, input rx_byte, input rx_last, input to_host,
                    output ready);
endinterface

FILE: hdl/icmpe_tx_if.sv
// ----------------------------------------------------------------------------
// icmpe_tx_if
// Transmit word stream: reply words, big-endian, with a last flag.
// ----------------------------------------------------------------------------
interface icmpe_tx_if;
    logic        valid;
    logic        ready;
    logic [15:0] tx_word;
    logic        tx_last;

    modport source (output valid, output tx_word, output tx_last, input ready);
    modport sink   (input valid, input tx_word, input tx_last, output ready);
endinterface

FILE: hdl/icmpe_ctrl.sv
// ----------------------------------------------------------------------------
// icmpe_ctrl
// Sequencer: receive a frame, fold the checksums, then walk the reply words
// through read, load and handoff steps.
// ----------------------------------------------------------------------------
module icmpe_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  icmpe_pkg::t_dp_status  i_status,
    output icmpe_pkg::t_ctrl_cmd   o_cmd
);
    import icmpe_pkg::*;

    localparam logic [2:0] S_RECV = 3'd0;
    localparam logic [2:0] S_FOLD = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_RECV: begin
                o_cmd.rx_en = 1'b1;
                if (i_status.frame_ok) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.tx_taken) begin
                    if (i_status.last_word) begin
                        n_state = S_RECV;
                    end else begin
                        o_cmd.next_word = 1'b1;
                        n_state         = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/icmpe_datapath.sv
// ----------------------------------------------------------------------------
// icmpe_datapath
// Frame store, header capture, running checksum sums and the reply word
// builder with its output register.
// ----------------------------------------------------------------------------
module icmpe_datapath #(
    parameter int unsigned STORE_BYTES = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [31:0]            i_cfg_wdata,
    input  logic                   i_rx_valid,
    input  logic [7:0]             i_rx_byte,
    input  logic                   i_rx_last,
    input  logic                   i_to_host,
    input  logic                   i_tx_ready,
    input  icmpe_pkg::t_ctrl_cmd   i_cmd,
    output icmpe_pkg::t_dp_status  o_status,
    output logic                   o_tx_valid,
    output logic [15:0]            o_tx_word,
    output logic                   o_tx_last
);
    import icmpe_pkg::*;

    localparam int unsigned AW = $clog2(STORE_BYTES);
    localparam int unsigned CW = $clog2(STORE_BYTES + 1);

    logic [7:0]        r_mem [STORE_BYTES];
    logic [CW-1:0]     r_count;
    logic [31:0]       r_host_ip;
    logic [7:0]        r_hi;
    logic [15:0]       r_etype;
    logic [7:0]        r_proto;
    logic [31:0]       r_dst;
    logic [SUM_W-1:0]  r_ip_sum;
    logic [SUM_W-1:0]  r_icmp_sum;
    logic [15:0]       r_ip_csum;
    logic [15:0]       r_icmp_csum;
    logic [WORD_W-1:0] r_word_idx;
    logic [7:0]        r_rd0;
    logic [7:0]        r_rd1;
    logic              r_tx_valid;
    logic [15:0]       r_tx_word;
    logic              r_tx_last;

    logic              w_accept;
    logic              w_room;
    logic              w_odd;
    logic              w_ip_word;
    logic              w_icmp_word;
    logic              w_match;
    logic              w_long_enough;
    logic [15:0]       w_pair;
    logic [AW-1:0]     w_p;
    logic [AW-1:0]     w_ra;
    logic [15:0]       w_word;

    function automatic logic [15:0] fold_csum(input logic [SUM_W-1:0] s);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = 17'(s[15:0]) + 17'(s[SUM_W-1:16]);
        s2 = s1[15:0] + 16'(s1[16]);
        return ~s2;
    endfunction

    assign w_accept = i_rx_valid && i_cmd.rx_en;
    assign w_room   = r_count < CW'(STORE_BYTES);
    assign w_odd    = r_count[0];
    assign w_pair   = {r_hi, i_rx_byte};

    // Checksum field and ICMP type/code are left out of the sums: they read as zero.
    assign w_ip_word   = w_odd && (r_count > CW'(IP_OFF)) && (r_count < CW'(ICMP_OFF))
                         && (r_count != CW'(IPCS_OFF + 1));
    assign w_icmp_word = w_odd && (r_count > CW'(ICMPCS_OFF + 1))
                         && (r_count < CW'(MIN_FRAME));

    assign w_match = (r_etype == ETHERTYPE_IPV4) && (r_proto == PROTO_ICMP)
                     && (r_dst == r_host_ip);

    icmpe_bytes_guard #(
        .CW (CW)
    ) u_len_guard (
        .i_count        (r_count),
        .i_min_less_one (CW'(MIN_FRAME - 1)),
        .o_long_enough  (w_long_enough)
    );

    assign o_status.frame_ok  = w_accept && i_rx_last && i_to_host && w_match
                                && w_long_enough;
    assign o_status.tx_taken  = r_tx_valid && i_tx_ready;
    assign o_status.last_word = r_word_idx == WORD_W'(REPLY_WORDS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_host_ip <= HOST_IP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_host_ip <= i_cfg_wdata;
            end
            if (w_accept) begin
                if (i_rx_last) begin
                    r_count <= '0;
                end else if (w_room) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    // Capture header fields and accumulate word sums as bytes stream in.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hi <= i_rx_byte;
            if (r_count == CW'(ETYPE_OFF)) begin
                r_etype[15:8] <= i_rx_byte;
            end
            if (r_count == CW'(ETYPE_OFF + 1)) begin
                r_etype[7:0] <= i_rx_byte;
            end
            if (r_count == CW'(PROTO_OFF)) begin
                r_proto <= i_rx_byte;
            end
            if ((r_count >= CW'(DST_OFF)) && (r_count < CW'(ICMP_OFF))) begin
                r_dst <= {r_dst[23:0], i_rx_byte};
            end
            if (r_count == '0) begin
                r_ip_sum   <= '0;
                r_icmp_sum <= '0;
            end else begin
                if (w_ip_word) begin
                    r_ip_sum <= r_ip_sum + SUM_W'(w_pair);
                end
                if (w_icmp_word) begin
                    r_icmp_sum <= r_icmp_sum + SUM_W'(w_pair);
                end
            end
        end
        if (i_cmd.fold) begin
            r_ip_csum   <= fold_csum(r_ip_sum);
            r_icmp_csum <= fold_csum(r_icmp_sum);
        end
    end

    // Byte position of the current reply word; swap source and destination on read.
    assign w_p = AW'(IP_OFF) + AW'({r_word_idx, 1'b0});

    always_comb begin
        w_ra = w_p;
        if ((w_p >= AW'(SRC_OFF)) && (w_p < AW'(DST_OFF))) begin
            w_ra = w_p + AW'(DST_OFF - SRC_OFF);
        end else if ((w_p >= AW'(DST_OFF)) && (w_p < AW'(ICMP_OFF))) begin
            w_ra = w_p - AW'(DST_OFF - SRC_OFF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            r_mem[r_count[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd) begin
            r_rd0 <= r_mem[w_ra];
            r_rd1 <= r_mem[w_ra + AW'(1)];
        end
    end

    always_comb begin
        w_word = {r_rd0, r_rd1};
        if (w_p == AW'(IPCS_OFF)) begin
            w_word = r_ip_csum;
        end else if (w_p == AW'(ICMP_OFF)) begin
            w_word = '0;
        end else if (w_p == AW'(ICMPCS_OFF)) begin
            w_word = r_icmp_csum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fold) begin
            r_word_idx <= '0;
        end else if (i_cmd.next_word) begin
            r_word_idx <= r_word_idx + WORD_W'(1);
        end
        if (i_cmd.load) begin
            r_tx_word <= w_word;
            r_tx_last <= o_status.last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_tx_valid <= 1'b1;
        end else if (o_status.tx_taken) begin
            r_tx_valid <= 1'b0;
        end
    end

    assign o_tx_valid = r_tx_valid;
    assign o_tx_word  = r_tx_word;
    assign o_tx_last  = r_tx_last;

endmodule

FILE: hdl/icmpe_echo_responder_top_note.sv
// ----------------------------------------------------------------------------
// icmpe_bytes_guard
// Frame length gate: flags a received frame as long enough to hold an echo
// request once its final byte arrives.
// ----------------------------------------------------------------------------
module icmpe_bytes_guard #(
    parameter int unsigned CW = 8
) (
    input  logic [CW-1:0] i_count,
    input  logic [CW-1:0] i_min_less_one,
    output logic          o_long_enough
);
    assign o_long_enough = i_count >= i_min_less_one;
endmodule

FILE: hdl/icmp_echo_responder.sv
// Latency: the first reply word becomes valid after the fold, read and load states that follow the final frame byte.
// Throughput: frame bytes are taken one per cycle while receiving; each reply word passes memory read,
//   word build and handoff before the next word is read, and waits in handoff while the sink is not ready.
// Input is stalled from the final byte of a matching frame until the last word is taken.
// Reset: byte count, sequencer and output valid clear; host_ip returns to 192.168.4.2.
//   The frame store is not cleared.
// ----------------------------------------------------------------------------
// icmp_echo_responder
// Answers ICMP echo requests addressed to this host with the 84-byte IP reply.
// ----------------------------------------------------------------------------
module icmp_echo_responder #(
    parameter int unsigned STORE_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    icmpe_rx_if.sink    i_rx,
    icmpe_tx_if.source  o_tx
);
    import icmpe_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    assign i_rx.ready = w_cmd.rx_en;

    icmpe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    icmpe_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_valid  (i_rx.valid),
        .i_rx_byte   (i_rx.rx_byte),
        .i_rx_last   (i_rx.rx_last),
        .i_to_host   (i_rx.to_host),
        .i_tx_ready  (o_tx.ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_tx_valid  (o_tx.valid),
        .o_tx_word   (o_tx.tx_word),
        .o_tx_last   (o_tx.tx_last)
    );

endmodule
